/* sv/gbe_pkg.sv */
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and codes of the gap-buffer edit engine.
// ----------------------------------------------------------------------------
package gbe_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // Classified item: position and count already folded and clamped at zero
   // where that does not depend on the text.
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] pos;
      logic signed [15:0] cnt;
      logic [7:0]         data;
   } item_type;

endpackage

/* sv/gbe_front.sv */
// ----------------------------------------------------------------------------
// gbe_front
// Accept request beats, classify them, and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module gbe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_func,
   input  logic signed [13:0]   req_position,
   input  logic signed [13:0]   req_count,
   input  logic [7:0]           req_data_byte,
   input  logic                 pop,
   output logic                 head_valid,
   output gbe_pkg::item_type    head
);

   gbe_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   gbe_pkg::item_type cls;
   logic              push;
   logic              do_pop;
   logic signed [15:0] pos_x, cnt_x, p_t, n_t;

   // classify
   always_comb begin
      pos_x = {{2{req_position[13]}}, req_position};
      cnt_x = {{2{req_count[13]}}, req_count};
      p_t   = pos_x;
      n_t   = cnt_x;
      unique case (req_func)
         gbe_pkg::FUNC_INSERT: begin
            if (pos_x < 0) p_t = '0;
         end
         gbe_pkg::FUNC_DELETE: begin
            // fold a negative count, then cut the region at zero
            if (cnt_x < 0) begin
               p_t = pos_x + cnt_x;
               n_t = -cnt_x;
            end
            if (p_t < 0) begin
               n_t = n_t + p_t;
               p_t = '0;
            end
         end
         gbe_pkg::FUNC_READ: begin
            p_t = pos_x;
         end
         gbe_pkg::FUNC_NONE: begin
            p_t = '0;
            n_t = '0;
         end
      endcase
      cls.kind = req_func;
      cls.pos  = p_t;
      cls.cnt  = n_t;
      cls.data = req_data_byte;
   end

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (fill_ff != 2'd0);
   assign do_pop     = pop && head_valid;
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

endmodule

/* sv/gbe_back.sv */
// ----------------------------------------------------------------------------
// gbe_back
// Execute queued items against the byte store: move the gap, type, delete,
// read, and drive the result strobe.
// ----------------------------------------------------------------------------
module gbe_back #(
   parameter int CAPACITY = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  gbe_pkg::item_type head,
   output logic              pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_read_valid,
   output logic [12:0]       rsp_text_length,
   output logic [12:0]       rsp_gap_at,
   output logic              rsp_overflow
);

   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int AW     = ((LEN_W > 16) ? LEN_W : 16) + 2;
   localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MOVE = 3'd1;
   localparam logic [2:0] ST_MVWR = 3'd2;
   localparam logic [2:0] ST_EXEC = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;

   logic [7:0]        mem [CAPACITY];
   logic [7:0]        rdata_ff;
   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   logic [7:0]        mem_wdata;

   logic [2:0]        state_ff, state_in;
   gbe_pkg::item_type cur_ff, cur_in;
   logic [LEN_W-1:0]  bg_ff, bg_in, tot_ff, tot_in, tgt_ff, tgt_in, deln_ff, deln_in;
   logic [12:0]       run_ff, run_in;
   logic              rv_ff, rv_in, rrv_ff, rrv_in, ovf_ff, ovf_in;
   logic [7:0]        rb_ff, rb_in;
   logic [12:0]       rl_ff, rl_in, rg_ff, rg_in;
   logic              resp;

   logic [LEN_W-1:0]   base;
   logic signed [AW-1:0] p_s, n_s, tot_s, bg_s, end_s;

   assign base = CAP_L - tot_ff;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      bg_in     = bg_ff;
      tot_in    = tot_ff;
      tgt_in    = tgt_ff;
      deln_in   = deln_ff;
      run_in    = run_ff;
      pop       = 1'b0;
      resp      = 1'b0;
      rb_in     = 8'd0;
      rrv_in    = 1'b0;
      ovf_in    = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_raddr = '0;
      mem_waddr = '0;
      mem_wdata = rdata_ff;
      p_s       = AW'(head.pos);
      n_s       = AW'(head.cnt);
      tot_s     = AW'(signed'({1'b0, tot_ff}));
      bg_s      = AW'(signed'({1'b0, bg_ff}));
      end_s     = p_s + n_s;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               unique case (head.kind)
                  gbe_pkg::FUNC_INSERT: begin
                     if (run_ff != 13'd0) begin
                        run_in   = run_ff - 13'd1;
                        state_in = ST_EXEC;
                     end else if (n_s > 0) begin
                        run_in   = 13'(n_s - 1);
                        tgt_in   = (p_s > tot_s) ? tot_ff : LEN_W'(p_s);
                        state_in = ST_MOVE;
                     end else begin
                        resp = 1'b1;
                     end
                  end
                  gbe_pkg::FUNC_DELETE: begin
                     run_in = 13'd0;
                     // cut the region at the end of the text
                     if (end_s > tot_s) begin
                        n_s   = tot_s - p_s;
                        end_s = tot_s;
                     end
                     if (n_s > 0) begin
                        if (end_s == bg_s) begin
                           bg_in  = bg_ff - LEN_W'(n_s);
                           tot_in = tot_ff - LEN_W'(n_s);
                           resp   = 1'b1;
                        end else begin
                           tgt_in   = LEN_W'(p_s);
                           deln_in  = LEN_W'(n_s);
                           state_in = ST_MOVE;
                        end
                     end else begin
                        resp = 1'b1;
                     end
                  end
                  gbe_pkg::FUNC_READ: begin
                     if (p_s >= 0 && p_s < tot_s) begin
                        mem_re    = 1'b1;
                        mem_raddr = (p_s >= bg_s) ? ADDR_W'(LEN_W'(p_s) + base)
                                                  : ADDR_W'(p_s);
                        state_in  = ST_READ;
                     end else begin
                        resp = 1'b1;
                     end
                  end
                  gbe_pkg::FUNC_NONE: begin
                     resp = 1'b1;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            // read one byte across the gap, or end the move once the gap is at the target
            if (bg_ff == tgt_ff) begin
               state_in = ST_EXEC;
            end else if (bg_ff < tgt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(base + bg_ff);
               state_in  = ST_MVWR;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(bg_ff - LEN_W'(1));
               state_in  = ST_MVWR;
            end
         end
         ST_MVWR: begin
            mem_we = 1'b1;
            if (bg_ff < tgt_ff) begin
               mem_waddr = ADDR_W'(bg_ff);
               bg_in     = bg_ff + LEN_W'(1);
            end else begin
               mem_waddr = ADDR_W'(base + bg_ff - LEN_W'(1));
               bg_in     = bg_ff - LEN_W'(1);
            end
            state_in = ST_MOVE;
         end
         ST_EXEC: begin
            resp     = 1'b1;
            state_in = ST_IDLE;
            if (cur_ff.kind == gbe_pkg::FUNC_INSERT) begin
               if (tot_ff >= CAP_L) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = ADDR_W'(bg_ff);
                  mem_wdata = cur_ff.data;
                  bg_in     = bg_ff + LEN_W'(1);
                  tot_in    = tot_ff + LEN_W'(1);
               end
            end else begin
               tot_in = tot_ff - deln_ff;
            end
         end
         ST_READ: begin
            resp     = 1'b1;
            rb_in    = rdata_ff;
            rrv_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rv_in = resp;
      rl_in = 13'(tot_in);
      rg_in = 13'(bg_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bg_ff    <= '0;
         tot_ff   <= '0;
         run_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         bg_ff    <= bg_in;
         tot_ff   <= tot_in;
         run_ff   <= run_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      tgt_ff  <= tgt_in;
      deln_ff <= deln_in;
      if (resp) begin
         rb_ff  <= rb_in;
         rrv_ff <= rrv_in;
         ovf_ff <= ovf_in;
         rl_ff  <= rl_in;
         rg_ff  <= rg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   assign rsp_valid       = rv_ff;
   assign rsp_read_byte   = rb_ff;
   assign rsp_read_valid  = rrv_ff;
   assign rsp_text_length = rl_ff;
   assign rsp_gap_at      = rg_ff;
   assign rsp_overflow    = ovf_ff;

   a_gap_in_text: assert property (@(posedge clock) disable iff (reset)
      bg_ff <= tot_ff) else $error("gap beyond text end");
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      tot_ff <= CAP_L) else $error("text longer than store");
   a_mvwr_after_move: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MVWR |-> $past(state_ff) == ST_MOVE)
      else $error("gap write without read");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE) else $error("pop while busy");

endmodule

/* sv/gap_buffer_edit_engine.sv */
// ----------------------------------------------------------------------------
// gap_buffer_edit_engine
// Gap-buffer text store with insert, delete and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a beat is taken on a rising edge with start high and
//   busy low. req_func selects insert (0), delete (1) or read (2).
//   Result channel: one beat per request, shown for one cycle with
//   rsp_valid high; the receiver cannot stall it.
//   A two-entry queue parts the front (accept, classify) from the back
//   (execute). busy rises only when the queue is full.
// Path, accepting edge to the edge that raises rsp_valid, back idle:
//   Empty insert/delete, delete ending at the gap, read outside the text,
//   unused code: answered from idle. Insert inside a run: via execute; read
//   inside the text: via the read state. A run's first insert or a delete off
//   the gap: the gap moves byte by byte, a read then a write each, then execute.
// Throughput: the back runs one item at a time; queued beats wait.
// Reset:
//   Synchronous, active high. Empties the text and the queue and closes any
//   open run; store contents stay undefined until written.
// ----------------------------------------------------------------------------
module gap_buffer_edit_engine #(
   parameter int CAPACITY = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic signed [13:0]  req_position,
   input  logic signed [13:0]  req_count,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_read_valid,
   output logic [12:0]         rsp_text_length,
   output logic [12:0]         rsp_gap_at,
   output logic                rsp_overflow
);

   gbe_pkg::item_type head;
   logic              head_valid;
   logic              pop;

   // accept and classify beats
   gbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_count     (req_count),
      .req_data_byte (req_data_byte),
      .pop           (pop),
      .head_valid    (head_valid),
      .head          (head)
   );

   // execute against the store
   gbe_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_text_length (rsp_text_length),
      .rsp_gap_at      (rsp_gap_at),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

/* test/gap_buffer_edit_checker.sv */
// ----------------------------------------------------------------------------
// gap_buffer_edit_checker
// Watches the request and result channels of the gap-buffer edit engine,
// predicts each result beat from its own copy of the text store and compares.
// ----------------------------------------------------------------------------
module gap_buffer_edit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [13:0] req_position,
   input  logic signed [13:0] req_count,
   input  logic [7:0]         req_data_byte,
   input  logic               rsp_valid,
   input  logic [7:0]         rsp_read_byte,
   input  logic               rsp_read_valid,
   input  logic [12:0]        rsp_text_length,
   input  logic [12:0]        rsp_gap_at,
   input  logic               rsp_overflow,
   output int                 fail_count,
   output int                 results_due,
   output int                 text_held,
   output int                 reads_hit,
   output int                 bytes_dropped
);

   localparam int STORE_BYTES = 4096;

   typedef struct {
      logic [7:0]  read_byte;
      logic        read_valid;
      logic [12:0] text_length;
      logic [12:0] gap_at;
      logic        overflow;
   } edit_outcome_type;

   edit_outcome_type due_outcomes[$];
   logic [7:0]       text_store[STORE_BYTES];
   int               gap_pos;
   int               text_len;
   int               run_left;

   assign results_due = due_outcomes.size();
   assign text_held   = text_len;

   task automatic move_gap(input int target);
      int base;
      base = STORE_BYTES - text_len;
      if (target > text_len || target == gap_pos) return;
      if (gap_pos < target) begin
         for (int i = gap_pos; i < target; i++) text_store[i] = text_store[base + i];
      end else begin
         for (int i = gap_pos - 1; i >= target; i--) text_store[base + i] = text_store[i];
      end
      gap_pos = target;
   endtask

   task automatic type_byte(input logic [7:0] value, inout logic dropped);
      if (text_len >= STORE_BYTES) begin
         dropped = 1'b1;
         return;
      end
      text_store[gap_pos] = value;
      gap_pos++;
      text_len++;
   endtask

   task automatic predict_edit(output edit_outcome_type res);
      int pos, cnt, idx;
      logic dropped;
      pos = req_position;
      cnt = req_count;
      dropped = 1'b0;
      res.read_byte  = '0;
      res.read_valid = 1'b0;
      case (req_func)
         gbe_pkg::FUNC_INSERT: begin
            if (run_left != 0) begin
               run_left--;
               type_byte(req_data_byte, dropped);
            end else if (cnt > 0) begin
               if (pos < 0) pos = 0;
               if (pos > text_len) pos = text_len;
               move_gap(pos);
               run_left = cnt - 1;
               type_byte(req_data_byte, dropped);
            end
         end
         gbe_pkg::FUNC_DELETE: begin
            run_left = 0;
            // fold a negative count below the position
            if (cnt < 0) begin
               pos = pos + cnt;
               cnt = -cnt;
            end
            if (pos < 0) begin
               cnt = cnt + pos;
               pos = 0;
            end
            if (pos + cnt > text_len) cnt = text_len - pos;
            if (cnt > 0) begin
               if (pos + cnt == gap_pos) gap_pos -= cnt;
               else move_gap(pos);
               text_len -= cnt;
            end
         end
         gbe_pkg::FUNC_READ: begin
            if (pos >= 0 && pos < text_len) begin
               idx = (pos >= gap_pos) ? pos + STORE_BYTES - text_len : pos;
               res.read_byte  = text_store[idx];
               res.read_valid = 1'b1;
               reads_hit++;
            end
         end
         default: ;
      endcase
      if (dropped) bytes_dropped++;
      res.text_length = text_len[12:0];
      res.gap_at      = gap_pos[12:0];
      res.overflow    = dropped;
   endtask

   always @(posedge clock) begin
      edit_outcome_type want, got;
      if (reset) begin
         due_outcomes.delete();
         gap_pos  = 0;
         text_len = 0;
         run_left = 0;
         fail_count    = 0;
         reads_hit     = 0;
         bytes_dropped = 0;
      end else begin
         // compare first: a result can never belong to the beat taken now
         if (rsp_valid) begin
            got = '{rsp_read_byte, rsp_read_valid, rsp_text_length, rsp_gap_at,
                    rsp_overflow};
            if (due_outcomes.size() == 0) begin
               $display("%0t: result beat with nothing due", $time);
               fail_count++;
            end else begin
               want = due_outcomes.pop_front();
               if (got.read_byte !== want.read_byte) begin
                  $display("%0t: read_byte expected %0h actual %0h", $time,
                           want.read_byte, got.read_byte);
                  fail_count++;
               end
               if (got.read_valid !== want.read_valid) begin
                  $display("%0t: read_valid expected %0b actual %0b", $time,
                           want.read_valid, got.read_valid);
                  fail_count++;
               end
               if (got.text_length !== want.text_length) begin
                  $display("%0t: text_length expected %0d actual %0d", $time,
                           want.text_length, got.text_length);
                  fail_count++;
               end
               if (got.gap_at !== want.gap_at) begin
                  $display("%0t: gap_at expected %0d actual %0d", $time,
                           want.gap_at, got.gap_at);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0b actual %0b", $time,
                           want.overflow, got.overflow);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_edit(want);
            due_outcomes.push_back(want);
         end
      end
   end

endmodule

/* test/tb_gap_buffer_edit_engine.sv */
// ----------------------------------------------------------------------------
// tb_gap_buffer_edit_engine
// Drives insert runs, deletes, reads and unused codes into the gap-buffer edit
// engine with random idle bursts; a checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module tb_gap_buffer_edit_engine;

   localparam int STALL_LIMIT = 40000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_func = gbe_pkg::FUNC_NONE;
   logic signed [13:0] req_position = '0;
   logic signed [13:0] req_count = '0;
   logic [7:0]         req_data_byte = '0;
   logic               rsp_valid;
   logic [7:0]         rsp_read_byte;
   logic               rsp_read_valid;
   logic [12:0]        rsp_text_length;
   logic [12:0]        rsp_gap_at;
   logic               rsp_overflow;

   int  fail_count, results_due, text_held, reads_hit, bytes_dropped;
   int  beats_sent = 0;
   int  idle_cycles = 0;
   bit  allow_idle = 1'b1;

   always #6 clock = ~clock;

   gap_buffer_edit_engine u_dut (
      .clock, .reset, .start, .busy,
      .req_func, .req_position, .req_count, .req_data_byte,
      .rsp_valid, .rsp_read_byte, .rsp_read_valid,
      .rsp_text_length, .rsp_gap_at, .rsp_overflow
   );

   gap_buffer_edit_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_func, .req_position, .req_count, .req_data_byte,
      .rsp_valid, .rsp_read_byte, .rsp_read_valid,
      .rsp_text_length, .rsp_gap_at, .rsp_overflow,
      .fail_count, .results_due, .text_held, .reads_hit, .bytes_dropped
   );

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("gap_buffer_edit_engine: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one beat. Called right after a rising edge; returns at the edge
   // that takes the beat. busy only moves at edges, so check it mid-cycle.
   task automatic send_edit(input logic [1:0] func, input int pos, input int cnt,
                            input logic [7:0] value);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_position  <= pos[13:0];
      req_count     <= cnt[13:0];
      req_data_byte <= value;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      beats_sent++;
   endtask

   function automatic int any14();
      return $signed($urandom_range(0, 16383) - 8192);
   endfunction

   // Well-formed insert run of run_len bytes, with the odd read slipped in
   // (a read must leave the run open).
   task automatic insert_run(input int pos, input int run_len);
      for (int i = 0; i < run_len; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0)
            send_edit(gbe_pkg::FUNC_READ, $urandom_range(0, text_held + 2), any14(),
                      8'($urandom));
         // position and count are don't-care inside a run: randomize them
         send_edit(gbe_pkg::FUNC_INSERT, (i == 0) ? pos : any14(),
                   (i == 0) ? run_len : any14(), 8'($urandom));
      end
   endtask

   initial begin
      int kind, len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // -------- directed part --------
      send_edit(gbe_pkg::FUNC_READ,   0, 0, 8'h00);     // read of empty text
      send_edit(gbe_pkg::FUNC_DELETE, 0, 5, 8'h00);     // delete on empty text
      send_edit(gbe_pkg::FUNC_INSERT, 0, 0, 8'hff);     // zero count: no run
      send_edit(gbe_pkg::FUNC_INSERT, 0, -3, 8'hff);    // negative count: no run
      insert_run(-5, 3);                                // position clamped to zero
      insert_run(8191, 2);                              // position clamped to length
      send_edit(gbe_pkg::FUNC_READ,   -1, 0, 8'h00);    // read below the text
      send_edit(gbe_pkg::FUNC_READ,   5, 0, 8'h00);     // read at the length
      send_edit(gbe_pkg::FUNC_READ,   8191, 0, 8'h00);
      send_edit(gbe_pkg::FUNC_READ,   -8192, 0, 8'h00);
      send_edit(gbe_pkg::FUNC_NONE,   1, 1, 8'haa);     // unused code
      send_edit(gbe_pkg::FUNC_DELETE, 3, -2, 8'h00);    // negative count folds down
      send_edit(gbe_pkg::FUNC_DELETE, 0, 1, 8'h00);     // region ending at the gap
      send_edit(gbe_pkg::FUNC_DELETE, -4, 5, 8'h00);    // region cut at zero
      send_edit(gbe_pkg::FUNC_DELETE, 0, 8191, 8'h00);  // region cut at the length
      send_edit(gbe_pkg::FUNC_INSERT, 0, 8191, 8'h5a);  // open a long run ...
      send_edit(gbe_pkg::FUNC_DELETE, 0, -8192, 8'h00); // ... and close it

      // -------- random part --------
      while (beats_sent < 950) begin
         // drop idling for the final stretch
         if (beats_sent > 800) allow_idle = 1'b0;
         kind = $urandom_range(0, 19);
         if (kind < 9) begin
            len = $urandom_range(1, 12);
            insert_run($urandom_range(0, 3) == 0 ? any14() :
                       $urandom_range(0, text_held + 1), len);
         end else if (kind < 13) begin
            if (text_held > 150 || $urandom_range(0, 3) == 0)
               send_edit(gbe_pkg::FUNC_DELETE, any14(), any14(), 8'($urandom));
            else
               send_edit(gbe_pkg::FUNC_DELETE, $urandom_range(0, text_held),
                         $signed($urandom_range(0, 16)) - 8, 8'($urandom));
         end else if (kind < 18) begin
            send_edit(gbe_pkg::FUNC_READ, $urandom_range(0, 4) == 0 ? any14() :
                      $urandom_range(0, text_held), any14(), 8'($urandom));
         end else if (kind == 18) begin
            send_edit(gbe_pkg::FUNC_NONE, any14(), any14(), 8'($urandom));
         end else begin
            // hand-rolled broken run: open it then cut it short with a delete
            send_edit(gbe_pkg::FUNC_INSERT, $urandom_range(0, text_held), 9,
                      8'($urandom));
            send_edit(gbe_pkg::FUNC_DELETE, $urandom_range(0, text_held), 1,
                      8'($urandom));
         end
      end
      start <= 1'b0;

      // drain, then leave room for a stray late beat
      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d beats: insert runs, deletes, reads, unused codes", beats_sent);
      $display("%0d reads inside the text, %0d bytes dropped on a full store",
               reads_hit, bytes_dropped);
      if (fail_count == 0 && results_due == 0) begin
         $display("gap_buffer_edit_engine: match");
      end else begin
         $display("gap_buffer_edit_engine: mismatch");
      end
      $finish;
   end

endmodule
